FILE: rtl/shgt_pkg.sv
// Package for the spatial hash grid table: sizes, codes, payload and
// controller/datapath interface types. No dependencies.
package shgt_pkg;

  localparam int TABLE_SLOTS  = 256;
  localparam int BUCKET_DEPTH = 4;
  localparam int SPILL_DEPTH  = 32;
  localparam int MAX_ITEMS    = 64;

  localparam logic [31:0] HASH_KX = 32'd73856093;
  localparam logic [31:0] HASH_KY = 32'd19349663;

  localparam int CELL_W  = 24;                       // stored cell coordinate
  localparam int QCELL_W = 25;                       // query window coordinate
  localparam int IDX_W   = $clog2(TABLE_SLOTS);
  localparam int BKT_W   = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int FILL_W  = $clog2(BUCKET_DEPTH + 1);
  localparam int SP_W    = $clog2(SPILL_DEPTH);
  localparam int SPF_W   = $clog2(SPILL_DEPTH + 1);
  localparam int KMAX    = (BUCKET_DEPTH > SPILL_DEPTH) ? BUCKET_DEPTH : SPILL_DEPTH;
  localparam int K_W     = $clog2(KMAX + 1);
  localparam int N_W     = $clog2(MAX_ITEMS + 1);
  localparam int KEY_W   = 2 * CELL_W;
  localparam int SLOT_W  = KEY_W + FILL_W;          // {cx, cy, fill}
  localparam int SPILL_W = KEY_W + 16;              // {cx, cy, agent}
  localparam int MEM_DEPTH = TABLE_SLOTS << BKT_W;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_BUCKET = 3'd0,
    ST_SPILL  = 3'd1,
    ST_TFULL  = 3'd2,
    ST_SFULL  = 3'd3,
    ST_DONE   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_CLEAR, S_MUL, S_HASH, S_PRD, S_PEV,
    S_QINIT, S_SRD, S_SEV, S_SEND, S_MRD, S_MEV, S_XRD, S_XEV, S_QFIN
  } state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        agent_id;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [22:0]        radius;
  } req_t;

  typedef struct packed {
    logic [15:0] found_agent;
    logic        found;
    logic [2:0]  status;
    logic        truncated;
    logic        last;
  } res_t;

  typedef struct packed {
    logic    load;
    logic    mul;
    logic    hash;
    logic    probe_next;
    logic    ins_new;
    logic    ins_add;
    logic    ins_spill;
    logic    clear;
    logic    q_init;
    logic    scan_start;
    logic    scan_eval;
    logic    cell_begin;
    logic    spill_begin;
    logic    k_inc;
    logic    hit_mem;
    logic    hit_spill;
    logic    emit_status;
    logic    emit_final;
    status_e out_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       mul_last;
    logic       slot_free;
    logic       slot_match;
    logic       bucket_full;
    logic       spill_full;
    logic       probe_last;
    logic       scan_last;
    logic       have_best;
    logic       k_at_fill;
    logic       k_at_spill;
    logic       spill_match;
    logic       n_full;
  } stat_t;

endpackage

FILE: rtl/shgt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module shgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/shgt_ctrl.sv
// Controller state machine of the spatial hash grid table.
// Depends on shgt_pkg; drives the datapath by cmd_t, reads stat_t.
module shgt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  shgt_pkg::stat_t stat_i,
  output shgt_pkg::cmd_t  cmd_o,
  output logic            busy
);
  import shgt_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_status = ST_DONE;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.op inside {OP_INSERT, OP_QUERY}) begin
          state_d = S_MUL;
        end else if (stat_i.op == OP_CLEAR) begin
          state_d = S_CLEAR;
        end else begin
          cmd_o.emit_status = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd_o.clear       = 1'b1;
        cmd_o.emit_status = 1'b1;
        state_d           = S_IDLE;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        if (stat_i.mul_last) begin
          state_d = (stat_i.op == OP_INSERT) ? S_HASH : S_QINIT;
        end
      end
      S_HASH: begin
        cmd_o.hash = 1'b1;
        state_d    = S_PRD;
      end
      S_PRD: begin
        state_d = S_PEV;
      end
      // probe evaluation: free slot, own cell, next slot, or table full
      S_PEV: begin
        state_d = S_IDLE;
        if (stat_i.slot_free) begin
          cmd_o.ins_new     = 1'b1;
          cmd_o.emit_status = 1'b1;
          cmd_o.out_status  = ST_BUCKET;
        end else if (stat_i.slot_match) begin
          cmd_o.emit_status = 1'b1;
          if (!stat_i.bucket_full) begin
            cmd_o.ins_add    = 1'b1;
            cmd_o.out_status = ST_BUCKET;
          end else if (stat_i.spill_full) begin
            cmd_o.out_status = ST_SFULL;
          end else begin
            cmd_o.ins_spill  = 1'b1;
            cmd_o.out_status = ST_SPILL;
          end
        end else if (stat_i.probe_last) begin
          cmd_o.emit_status = 1'b1;
          cmd_o.out_status  = ST_TFULL;
        end else begin
          cmd_o.probe_next = 1'b1;
          state_d          = S_PRD;
        end
      end
      S_QINIT: begin
        cmd_o.q_init     = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = S_SRD;
      end
      S_SRD: begin
        state_d = S_SEV;
      end
      S_SEV: begin
        cmd_o.scan_eval = 1'b1;
        state_d         = stat_i.scan_last ? S_SEND : S_SRD;
      end
      S_SEND: begin
        if (stat_i.have_best) begin
          cmd_o.cell_begin = 1'b1;
          state_d          = S_MRD;
        end else begin
          state_d = S_QFIN;
        end
      end
      // bucket members of the selected cell
      S_MRD: begin
        if (stat_i.k_at_fill) begin
          cmd_o.spill_begin = 1'b1;
          state_d           = S_XRD;
        end else begin
          state_d = S_MEV;
        end
      end
      S_MEV: begin
        cmd_o.hit_mem = 1'b1;
        cmd_o.k_inc   = 1'b1;
        state_d       = stat_i.n_full ? S_IDLE : S_MRD;
      end
      // spill entries of the selected cell
      S_XRD: begin
        if (stat_i.k_at_spill) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SRD;
        end else begin
          state_d = S_XEV;
        end
      end
      S_XEV: begin
        cmd_o.k_inc = 1'b1;
        state_d     = S_XRD;
        if (stat_i.spill_match) begin
          cmd_o.hit_spill = 1'b1;
          if (stat_i.n_full) begin
            state_d = S_IDLE;
          end
        end
      end
      S_QFIN: begin
        cmd_o.emit_final = 1'b1;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/shgt_dp.sv
// Datapath of the spatial hash grid table: cell mapping, hashing, slot,
// member and spill stores, query selection and result register.
// Depends on shgt_pkg and shgt_ram.
module shgt_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  shgt_pkg::req_t  req_i,
  input  logic [15:0]     inv_i,
  input  shgt_pkg::cmd_t  cmd_i,
  output shgt_pkg::stat_t stat_o,
  output shgt_pkg::res_t  res_o,
  output logic            res_valid_o
);
  import shgt_pkg::*;

  // latched request
  logic [1:0]                op_q;
  logic [15:0]               agent_q;
  logic signed [QCELL_W-1:0] ax_q, bx_q, ay_q, by_q;
  logic signed [QCELL_W-1:0] cx0_q, cx1_q, cy0_q, cy1_q;
  logic [1:0]                mstep_q;

  // indexes and counters
  logic [IDX_W-1:0] idx_q, pcnt_q, best_idx_q;
  logic [K_W-1:0]   k_q;
  logic [N_W-1:0]   n_q;
  logic [SPF_W-1:0] spill_fill_q;
  logic [TABLE_SLOTS-1:0] used_q;

  // query selection
  logic [KEY_W-1:0]  best_key_q, prev_key_q;
  logic [FILL_W-1:0] best_fill_q;
  logic              have_best_q, have_prev_q;
  logic [15:0]       pend_agent_q;
  logic              pend_valid_q;

  res_t res_q, res_d;
  logic res_valid_q, res_valid_d;

  // memory ports
  logic [SLOT_W-1:0]  slot_rd, slot_wd;
  logic               slot_we;
  logic [15:0]        mem_rd;
  logic               mem_we;
  logic [BKT_W-1:0]   mem_wk;
  logic [SPILL_W-1:0] spill_rd;
  logic               spill_we;

  // slot word fields
  logic [CELL_W-1:0] s_cx, s_cy, x_cx, x_cy;
  logic [FILL_W-1:0] s_fill;
  logic [KEY_W-1:0]  s_key;
  logic              s_used;

  assign s_cx   = slot_rd[SLOT_W-1 -: CELL_W];
  assign s_cy   = slot_rd[SLOT_W-CELL_W-1 -: CELL_W];
  assign s_fill = slot_rd[FILL_W-1:0];
  assign s_used = used_q[idx_q];
  // ordering key: cy then cx, signed
  assign s_key  = {~s_cy[CELL_W-1], s_cy[CELL_W-2:0], ~s_cx[CELL_W-1], s_cx[CELL_W-2:0]};
  assign x_cx   = spill_rd[SPILL_W-1 -: CELL_W];
  assign x_cy   = spill_rd[SPILL_W-CELL_W-1 -: CELL_W];

  // cell mapping: floor(p * inv / 65536)
  logic signed [QCELL_W-1:0] mul_a;
  logic signed [41:0]        prod;
  always_comb begin
    case (mstep_q)
      2'd0:    mul_a = ax_q;
      2'd1:    mul_a = bx_q;
      2'd2:    mul_a = ay_q;
      default: mul_a = by_q;
    endcase
  end
  assign prod = mul_a * $signed({1'b0, inv_i});

  // slot hash: only the low index bits of each product matter
  logic [2*IDX_W-1:0] hx, hy;
  assign hx = cx0_q[IDX_W-1:0] * HASH_KX[IDX_W-1:0];
  assign hy = cy0_q[IDX_W-1:0] * HASH_KY[IDX_W-1:0];

  // window and order checks for the slot scan
  logic in_win, after_prev, before_best, take;
  assign in_win = ($signed({s_cx[CELL_W-1], s_cx}) >= cx0_q) &&
                  ($signed({s_cx[CELL_W-1], s_cx}) <= cx1_q) &&
                  ($signed({s_cy[CELL_W-1], s_cy}) >= cy0_q) &&
                  ($signed({s_cy[CELL_W-1], s_cy}) <= cy1_q);
  assign after_prev  = !have_prev_q || (s_key > prev_key_q);
  assign before_best = !have_best_q || (s_key < best_key_q);
  assign take = s_used && in_win && after_prev && before_best;

  // request, mapping and counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= req_i.opcode;
      agent_q <= req_i.agent_id;
      if (req_i.opcode == OP_INSERT) begin
        ax_q <= QCELL_W'(req_i.pos_x);
        ay_q <= QCELL_W'(req_i.pos_y);
      end else begin
        ax_q <= QCELL_W'(req_i.pos_x) - $signed({2'b00, req_i.radius});
        ay_q <= QCELL_W'(req_i.pos_y) - $signed({2'b00, req_i.radius});
      end
      bx_q    <= QCELL_W'(req_i.pos_x) + $signed({2'b00, req_i.radius});
      by_q    <= QCELL_W'(req_i.pos_y) + $signed({2'b00, req_i.radius});
      mstep_q <= 2'd0;
    end
    if (cmd_i.mul) begin
      mstep_q <= mstep_q + 2'd1;
      case (mstep_q)
        2'd0:    cx0_q <= prod[40:16];
        2'd1:    cx1_q <= prod[40:16];
        2'd2:    cy0_q <= prod[40:16];
        default: cy1_q <= prod[40:16];
      endcase
    end
    if (cmd_i.hash) begin
      idx_q  <= hx[IDX_W-1:0] ^ hy[IDX_W-1:0];
      pcnt_q <= '0;
    end
    if (cmd_i.probe_next) begin
      idx_q  <= idx_q + IDX_W'(1);
      pcnt_q <= pcnt_q + IDX_W'(1);
    end
    if (cmd_i.scan_start) begin
      idx_q <= '0;
    end
    if (cmd_i.scan_eval) begin
      idx_q <= idx_q + IDX_W'(1);
      if (take) begin
        best_key_q  <= s_key;
        best_idx_q  <= idx_q;
        best_fill_q <= s_fill;
      end
    end
    if (cmd_i.cell_begin) begin
      prev_key_q <= best_key_q;
    end
    if (cmd_i.cell_begin || cmd_i.spill_begin) begin
      k_q <= '0;
    end
    if (cmd_i.k_inc) begin
      k_q <= k_q + K_W'(1);
    end
    if (cmd_i.hit_mem || cmd_i.hit_spill) begin
      pend_agent_q <= cmd_i.hit_mem ? mem_rd : spill_rd[15:0];
    end
  end

  // control flags of the stores and the query
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q       <= '0;
      spill_fill_q <= '0;
      have_best_q  <= 1'b0;
      have_prev_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      n_q          <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (cmd_i.clear) begin
        used_q       <= '0;
        spill_fill_q <= '0;
      end
      if (cmd_i.ins_new) begin
        used_q[idx_q] <= 1'b1;
      end
      if (cmd_i.ins_spill) begin
        spill_fill_q <= spill_fill_q + SPF_W'(1);
      end
      if (cmd_i.q_init) begin
        have_prev_q  <= 1'b0;
        pend_valid_q <= 1'b0;
        n_q          <= '0;
      end
      if (cmd_i.scan_start) begin
        have_best_q <= 1'b0;
      end
      if (cmd_i.scan_eval && take) begin
        have_best_q <= 1'b1;
      end
      if (cmd_i.cell_begin) begin
        have_prev_q <= 1'b1;
      end
      if ((cmd_i.hit_mem || cmd_i.hit_spill) && n_q != N_W'(MAX_ITEMS)) begin
        pend_valid_q <= 1'b1;
        n_q          <= n_q + N_W'(1);
      end
    end
  end

  // result register; a hit is held back in a pending register so the final flag is known
  always_comb begin
    res_valid_d = 1'b0;
    res_d       = res_q;
    if (cmd_i.emit_status) begin
      res_valid_d = 1'b1;
      res_d       = '{found_agent: 16'd0, found: 1'b0, status: cmd_i.out_status,
                      truncated: 1'b0, last: 1'b1};
    end else if (cmd_i.emit_final) begin
      res_valid_d = 1'b1;
      res_d       = '{found_agent: pend_valid_q ? pend_agent_q : 16'd0,
                      found: pend_valid_q, status: ST_DONE, truncated: 1'b0, last: 1'b1};
    end else if (cmd_i.hit_mem || cmd_i.hit_spill) begin
      res_valid_d = pend_valid_q;
      if (n_q == N_W'(MAX_ITEMS)) begin
        res_d = '{found_agent: pend_agent_q, found: 1'b1, status: ST_DONE,
                  truncated: 1'b1, last: 1'b1};
      end else begin
        res_d = '{found_agent: pend_agent_q, found: 1'b1, status: ST_DONE,
                  truncated: 1'b0, last: 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  // store writes
  assign slot_we  = cmd_i.ins_new || cmd_i.ins_add;
  assign slot_wd  = {cx0_q[CELL_W-1:0], cy0_q[CELL_W-1:0],
                     cmd_i.ins_new ? FILL_W'(1) : s_fill + FILL_W'(1)};
  assign mem_we   = slot_we;
  assign mem_wk   = cmd_i.ins_new ? '0 : s_fill[BKT_W-1:0];
  assign spill_we = cmd_i.ins_spill;

  shgt_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (idx_q),
    .wdata_i (slot_wd),
    .raddr_i (idx_q),
    .rdata_o (slot_rd)
  );

  shgt_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_member_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i ({idx_q, mem_wk}),
    .wdata_i (agent_q),
    .raddr_i ({best_idx_q, k_q[BKT_W-1:0]}),
    .rdata_o (mem_rd)
  );

  shgt_ram #(.WIDTH(SPILL_W), .DEPTH(SPILL_DEPTH)) u_spill_ram (
    .clk_i   (clk_i),
    .we_i    (spill_we),
    .waddr_i (spill_fill_q[SP_W-1:0]),
    .wdata_i ({cx0_q[CELL_W-1:0], cy0_q[CELL_W-1:0], agent_q}),
    .raddr_i (k_q[SP_W-1:0]),
    .rdata_o (spill_rd)
  );

  // status to the controller
  assign stat_o.op          = op_q;
  assign stat_o.mul_last    = (mstep_q == 2'd3);
  assign stat_o.slot_free   = !s_used;
  assign stat_o.slot_match  = (s_cx == cx0_q[CELL_W-1:0]) && (s_cy == cy0_q[CELL_W-1:0]);
  assign stat_o.bucket_full = (s_fill == FILL_W'(BUCKET_DEPTH));
  assign stat_o.spill_full  = (spill_fill_q == SPF_W'(SPILL_DEPTH));
  assign stat_o.probe_last  = (pcnt_q == IDX_W'(TABLE_SLOTS - 1));
  assign stat_o.scan_last   = (idx_q == IDX_W'(TABLE_SLOTS - 1));
  assign stat_o.have_best   = have_best_q;
  assign stat_o.k_at_fill   = (k_q == K_W'(best_fill_q));
  assign stat_o.k_at_spill  = (k_q == K_W'(spill_fill_q));
  assign stat_o.spill_match = ({x_cy, x_cx} == {best_key_q[KEY_W-1] ^ 1'b1,
                                best_key_q[KEY_W-2:CELL_W],
                                best_key_q[CELL_W-1] ^ 1'b1,
                                best_key_q[CELL_W-2:0]});
  assign stat_o.n_full      = (n_q == N_W'(MAX_ITEMS));

`ifndef SYNTHESIS
  a_n_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= N_W'(MAX_ITEMS)) else $error("query item count overran");
  a_spill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spill_fill_q <= SPF_W'(SPILL_DEPTH)) else $error("spill fill overran");
  a_pend_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> n_q != '0) else $error("held hit without count");
  a_cut_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.hit_mem || cmd_i.hit_spill) && n_q == N_W'(MAX_ITEMS) |-> pend_valid_q)
    else $error("cut without a held hit");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> used_q == '0 && spill_fill_q == '0) else $error("clear failed");
`endif

endmodule

FILE: rtl/spatial_hash_grid_table.sv
// Top level of the spatial hash grid table: configuration port and the
// controller/datapath pair. Depends on shgt_pkg, shgt_ctrl, shgt_dp.
//
// One command at a time: start is taken while busy is low. A clear and an
// unused opcode each report one status result. An insert reports once its
// probe ends (linear probing, one slot RAM read per step, at most
// TABLE_SLOTS steps). A query makes one pass per hit cell plus one more;
// each pass scans the whole slot RAM for the next cell in y-then-x order,
// then reads that cell's bucket members and scans the spill entries for
// it; a truncated query stops at the 65th hit. Results appear one per
// strobe cycle on res_o/res_valid_o and cannot be held off by the receiver;
// the last item of each command has last set and comes in the first cycle
// with busy low. No clearing pass: slot valid bits reset at once.
module spatial_hash_grid_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  shgt_pkg::req_t req_i,
  output shgt_pkg::res_t res_o,
  output logic           res_valid_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import shgt_pkg::*;

  logic [15:0] inv_q;
  cmd_t        cmd;
  stat_t       stat;
  logic        reg_sel;

  // configuration register
  assign reg_sel = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {16'd0, inv_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= 16'd256;
    end else if (psel && penable && pwrite && reg_sel) begin
      inv_q <= pwdata[15:0];
    end
  end

  shgt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  shgt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .inv_i       (inv_q),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for spatial_hash_grid_table: drives insert, query,
// clear and reserved-opcode commands and scale register writes, and checks every result
// transaction against an in-bench predictor. Depends on shgt_pkg and spatial_hash_grid_table.
`timescale 1ns / 100ps

module testbench;
  import shgt_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 30_000_000;
  localparam int SETTLE      = 40;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  req_t        req_i   = '0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic        busy;
  res_t        res_o;
  logic        res_valid_o;
  logic [31:0] prdata;
  logic        pready;

  spatial_hash_grid_table uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .res_o(res_o), .res_valid_o(res_valid_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  localparam logic [2:0] ADDR_INV_CELL = 3'd0;

  always #CLK_HALF clk_i = ~clk_i;

  // Predictor state
  logic [15:0] scale = 16'd256;
  bit          used_tbl [TABLE_SLOTS];
  longint      cell_x_tbl [TABLE_SLOTS];
  longint      cell_y_tbl [TABLE_SLOTS];
  int          fill_tbl [TABLE_SLOTS];
  logic [15:0] member_tbl [TABLE_SLOTS][BUCKET_DEPTH];
  longint      spill_x [SPILL_DEPTH];
  longint      spill_y [SPILL_DEPTH];
  logic [15:0] spill_id [SPILL_DEPTH];
  int          spill_cnt = 0;

  res_t pending_q[$];
  int   mismatches = 0;
  int   cycles = 0;
  bit   no_gaps = 0;

  function automatic longint cell_of(longint p);
    return (p * longint'(scale)) >>> 16;
  endfunction

  function automatic int slot_hash(longint cx, longint cy);
    logic [31:0] hx, hy;
    hx = 32'(cx * longint'(HASH_KX));
    hy = 32'(cy * longint'(HASH_KY));
    return int'((hx ^ hy) & (TABLE_SLOTS - 1));
  endfunction

  function automatic void wipe_tables();
    foreach (used_tbl[i]) begin
      used_tbl[i] = 0;
      fill_tbl[i] = 0;
    end
    spill_cnt = 0;
  endfunction

  function automatic status_e store_agent(logic [15:0] id, longint cx, longint cy);
    int h, s;
    h = slot_hash(cx, cy);
    for (int p = 0; p < TABLE_SLOTS; p++) begin
      s = (h + p) & (TABLE_SLOTS - 1);
      if (!used_tbl[s]) begin
        used_tbl[s] = 1;
        cell_x_tbl[s] = cx;
        cell_y_tbl[s] = cy;
        fill_tbl[s] = 1;
        member_tbl[s][0] = id;
        return ST_BUCKET;
      end
      if (cell_x_tbl[s] == cx && cell_y_tbl[s] == cy) begin
        if (fill_tbl[s] < BUCKET_DEPTH) begin
          member_tbl[s][fill_tbl[s]] = id;
          fill_tbl[s]++;
          return ST_BUCKET;
        end
        if (spill_cnt >= SPILL_DEPTH) return ST_SFULL;
        spill_x[spill_cnt] = cx;
        spill_y[spill_cnt] = cy;
        spill_id[spill_cnt] = id;
        spill_cnt++;
        return ST_SPILL;
      end
    end
    return ST_TFULL;
  endfunction

  function automatic res_t mk_res(logic [15:0] id, logic hit, status_e st);
    res_t r;
    r = '0;
    r.found_agent = id;
    r.found = hit;
    r.status = st;
    return r;
  endfunction

  // Box search: cells sorted by y then x, bucket then spill per cell
  function automatic void search_box(longint px, longint py, longint rad);
    longint x0, x1, y0, y1;
    int     hits[$];
    int     k, sl, n;
    bit     cut;
    res_t   found_q[$];
    x0 = cell_of(px - rad);
    x1 = cell_of(px + rad);
    y0 = cell_of(py - rad);
    y1 = cell_of(py + rad);
    cut = 0;
    n = 0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (used_tbl[i] && cell_x_tbl[i] >= x0 && cell_x_tbl[i] <= x1 &&
          cell_y_tbl[i] >= y0 && cell_y_tbl[i] <= y1) begin
        k = hits.size();
        while (k > 0 && (cell_y_tbl[i] < cell_y_tbl[hits[k-1]] ||
               (cell_y_tbl[i] == cell_y_tbl[hits[k-1]] &&
                cell_x_tbl[i] < cell_x_tbl[hits[k-1]])))
          k--;
        hits.insert(k, i);
      end
    end
    foreach (hits[j]) begin
      sl = hits[j];
      for (int m = 0; m < fill_tbl[sl] && !cut; m++) begin
        if (found_q.size() < MAX_ITEMS)
          found_q = {found_q, mk_res(member_tbl[sl][m], 1, ST_DONE)};
        else cut = 1;
      end
      for (int s = 0; s < spill_cnt && !cut; s++) begin
        if (spill_x[s] == cell_x_tbl[sl] && spill_y[s] == cell_y_tbl[sl]) begin
          if (found_q.size() < MAX_ITEMS)
            found_q = {found_q, mk_res(spill_id[s], 1, ST_DONE)};
          else cut = 1;
        end
      end
    end
    if (found_q.size() == 0) found_q = {found_q, mk_res(16'd0, 0, ST_DONE)};
    n = found_q.size();
    found_q[n-1].truncated = cut;
    found_q[n-1].last = 1'b1;
    pending_q = {pending_q, found_q};
  endfunction

  function automatic void predict_cmd(req_t r);
    res_t one;
    case (r.opcode)
      OP_INSERT: begin
        one = mk_res(16'd0, 0, store_agent(r.agent_id, cell_of(longint'(r.pos_x)),
                                             cell_of(longint'(r.pos_y))));
        one.last = 1'b1;
        pending_q = {pending_q, one};
      end
      OP_QUERY: search_box(longint'(r.pos_x), longint'(r.pos_y), longint'(r.radius));
      default: begin
        if (r.opcode == OP_CLEAR) wipe_tables();
        one = mk_res(16'd0, 0, ST_DONE);
        one.last = 1'b1;
        pending_q = {pending_q, one};
      end
    endcase
  endfunction

  function automatic void flag_mismatch(string what, res_t want, res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("MISMATCH %s: expected agent=%0d found=%0b status=%0d trunc=%0b last=%0b",
               what, want.found_agent, want.found, want.status, want.truncated,
               want.last);
      $display("  got agent=%0d found=%0b status=%0d trunc=%0b last=%0b",
               got.found_agent, got.found, got.status, got.truncated, got.last);
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (pending_q.size() == 0) flag_mismatch("unexpected result", '0, res_o);
      else if (res_o !== pending_q[0]) flag_mismatch("result", pending_q.pop_front(), res_o);
      else void'(pending_q.pop_front());
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("spatial_hash_grid_table verification failed");
      $finish;
    end
  end

  // One command transaction; start stays high for back-to-back commands
  task automatic send_cmd(req_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predict_cmd(r);
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    while (pending_q.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_scale(logic [15:0] v);
    wait_quiet();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_INV_CELL; pwdata <= {16'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    scale = v;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] !== v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH scale readback: expected %0d, got %0d", v, prdata[15:0]);
    end
    psel <= 1'b0; penable <= 1'b0;
  endtask

  function automatic req_t mk_req(opcode_e op, logic [15:0] id, logic [23:0] x,
                                  logic [23:0] y, logic [22:0] rad);
    req_t r;
    r.opcode = op;
    r.agent_id = id;
    r.pos_x = x;
    r.pos_y = y;
    r.radius = rad;
    return r;
  endfunction

  task automatic test_directed();
    send_cmd(mk_req(OP_CLEAR, 16'hFFFF, 24'h7FFFFF, 24'h800000, 23'h7FFFFF));
    send_cmd(mk_req(OP_RSVD, 16'hA5A5, 24'h123456, 24'h654321, 23'h55AA55));
    send_cmd(mk_req(OP_QUERY, 16'h0, 24'h0, 24'h0, 23'h7FFFFF));       // empty table
    send_cmd(mk_req(OP_INSERT, 16'h0000, 24'h000000, 24'h000000, 23'h0));
    send_cmd(mk_req(OP_INSERT, 16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF));
    send_cmd(mk_req(OP_INSERT, 16'h8001, 24'h800000, 24'h800000, 23'h0));
    send_cmd(mk_req(OP_INSERT, 16'h1234, 24'h7FFFFF, 24'h800000, 23'h0));
    send_cmd(mk_req(OP_INSERT, 16'h4321, 24'hFFFF00, 24'h0000FF, 23'h0));
    send_cmd(mk_req(OP_INSERT, 16'h5555, 24'h000080, 24'h000010, 23'h0)); // same cell as origin
    send_cmd(mk_req(OP_QUERY, 16'h0, 24'h000000, 24'h000000, 23'h0));
    send_cmd(mk_req(OP_QUERY, 16'h0, 24'h000000, 24'h000000, 23'h000100));
    send_cmd(mk_req(OP_QUERY, 16'h0, 24'h7FFFFF, 24'h7FFFFF, 23'h0));
    send_cmd(mk_req(OP_QUERY, 16'h0, 24'h800000, 24'h800000, 23'h7FFFFF));
    send_cmd(mk_req(OP_QUERY, 16'h0, 24'h400000, 24'hC00000, 23'h000001)); // empty window
    send_cmd(mk_req(OP_CLEAR, 16'h0, 24'h0, 24'h0, 23'h0));
    send_cmd(mk_req(OP_QUERY, 16'h0, 24'h0, 24'h0, 23'h7FFFFF));
  endtask

  // Fill one bucket, fill the spill store, then two more drop
  task automatic test_spill_full();
    send_cmd(mk_req(OP_CLEAR, 16'h0, 24'h0, 24'h0, 23'h0));
    for (int i = 0; i < BUCKET_DEPTH + SPILL_DEPTH + 2; i++)
      send_cmd(mk_req(OP_INSERT, 16'(i + 100), 24'h000310, 24'hFFFD20, 23'h0));
    send_cmd(mk_req(OP_INSERT, 16'h0777, 24'h000510, 24'h000000, 23'h0));
    send_cmd(mk_req(OP_QUERY, 16'h0, 24'h000300, 24'hFFFD00, 23'h000300));
  endtask

  // More hits than the item limit: the full spill cell plus eight full buckets
  task automatic test_truncation();
    for (int c = 0; c < 8; c++)
      for (int m = 0; m < BUCKET_DEPTH; m++)
        send_cmd(mk_req(OP_INSERT, 16'(c * 16 + m), 24'(c << 8), 24'hFFFE00, 23'h0));
    send_cmd(mk_req(OP_QUERY, 16'h0, 24'h000400, 24'hFFFD80, 23'h000480));
    send_cmd(mk_req(OP_QUERY, 16'h0, 24'h000100, 24'hFFFE00, 23'h0));
  endtask

  function automatic req_t rand_req();
    req_t r;
    int   sel;
    sel = $urandom_range(0, 99);
    r.agent_id = 16'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      r.pos_x = 24'($urandom);
      r.pos_y = 24'($urandom);
    end else begin
      r.pos_x = 24'($urandom_range(0, 4095) - 2048);
      r.pos_y = 24'($urandom_range(0, 4095) - 2048);
    end
    r.radius = ($urandom_range(0, 19) == 0) ? 23'($urandom) : 23'($urandom_range(0, 1024));
    if (sel < 55) r.opcode = OP_INSERT;
    else if (sel < 94) r.opcode = OP_QUERY;
    else if (sel < 97) r.opcode = OP_CLEAR;
    else r.opcode = OP_RSVD;
    return r;
  endfunction

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if (i == count / 2) wait_quiet();
      send_cmd(rand_req());
    end
    no_gaps = 0;
  endtask

  task automatic test_scales();
    write_scale(16'd1);
    test_random(20);
    write_scale(16'hFFFF);
    send_cmd(mk_req(OP_CLEAR, 16'h0, 24'h0, 24'h0, 23'h0));
    send_cmd(mk_req(OP_INSERT, 16'h0042, 24'h7FFFFF, 24'h800000, 23'h0));
    send_cmd(mk_req(OP_QUERY, 16'h0, 24'h7FFF00, 24'h800100, 23'h000100));
    test_random(20);
    write_scale(16'd300);
    test_random(25);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_spill_full();
    test_truncation();
    test_scales();
    wait_quiet();
    if (mismatches == 0 && pending_q.size() == 0)
      $display("spatial_hash_grid_table verification clean");
    else
      $display("spatial_hash_grid_table verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/shgt_pkg.sv
rtl/shgt_ram.sv
rtl/shgt_ctrl.sv
rtl/shgt_dp.sv
rtl/spatial_hash_grid_table.sv
tb/testbench.sv
